FILE: hdl/brse_pkg.sv
package brse_pkg;

    localparam int STACK_DEPTH_DEF = 64;

    localparam logic [2:0] CMD_PUSH_FACT = 3'd0;
    localparam logic [2:0] CMD_PUSH_CMP  = 3'd1;
    localparam logic [2:0] CMD_AND       = 3'd2;
    localparam logic [2:0] CMD_OR        = 3'd3;
    localparam logic [2:0] CMD_NOT       = 3'd4;
    localparam logic [2:0] CMD_HALT      = 3'd5;

    localparam logic [2:0] REL_LT = 3'd0;
    localparam logic [2:0] REL_LE = 3'd1;
    localparam logic [2:0] REL_GT = 3'd2;
    localparam logic [2:0] REL_GE = 3'd3;
    localparam logic [2:0] REL_EQ = 3'd4;
    localparam logic [2:0] REL_NE = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_HALT  = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;
    localparam logic [1:0] ST_OVER  = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD_ABOVE,
        CELL_LOAD_BELOW
    } t_cell_mode;

    typedef struct packed {
        logic [2:0]         cmd;
        logic               fact_flag;
        logic signed [31:0] fact_value;
        logic [2:0]         relation;
        logic signed [31:0] operand_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic       verdict;
    } t_out_item;

endpackage

FILE: hdl/boolean_rule_stack_evaluator.sv
// the result of an accepted instruction is written straight into the output register
// throughput: one instruction per cycle unless stalled; the stack is a row of one-bit shift cells
// with the top entry in cell 0; a push shifts every cell down, AND and OR shift every cell up
// a new instruction is taken while the previous result waits, unless it is stalled
// reset: synchronous active low, clears the depth counter and the output valid;
// the stack cells are not cleared
module boolean_rule_stack_evaluator #(
    parameter int STACK_DEPTH = brse_pkg::STACK_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  brse_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output brse_pkg::t_out_item o_out_data
);

    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic [DW-1:0]        r_depth;
    logic [DW-1:0]        n_depth;
    logic                 r_out_valid;
    brse_pkg::t_out_item  r_out_data;
    brse_pkg::t_out_item  n_out_data;

    logic                 w_accept;
    logic                 w_cmp;
    logic                 w_top_new;
    brse_pkg::t_cell_mode w_top_mode;
    brse_pkg::t_cell_mode w_rest_mode;
    logic                 w_bits [STACK_DEPTH];

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    always_comb begin
        unique case (i_in_data.relation)
            brse_pkg::REL_LT: w_cmp = i_in_data.fact_value <  i_in_data.operand_value;
            brse_pkg::REL_LE: w_cmp = i_in_data.fact_value <= i_in_data.operand_value;
            brse_pkg::REL_GT: w_cmp = i_in_data.fact_value >  i_in_data.operand_value;
            brse_pkg::REL_GE: w_cmp = i_in_data.fact_value >= i_in_data.operand_value;
            brse_pkg::REL_EQ: w_cmp = i_in_data.fact_value == i_in_data.operand_value;
            brse_pkg::REL_NE: w_cmp = i_in_data.fact_value != i_in_data.operand_value;
            default:          w_cmp = 1'b0;
        endcase
    end

    always_comb begin
        n_depth            = r_depth;
        w_top_mode         = brse_pkg::CELL_HOLD;
        w_rest_mode        = brse_pkg::CELL_HOLD;
        w_top_new          = 1'b0;
        n_out_data.status  = brse_pkg::ST_OK;
        n_out_data.verdict = 1'b0;
        if (w_accept) begin
            unique case (i_in_data.cmd)
                brse_pkg::CMD_PUSH_FACT, brse_pkg::CMD_PUSH_CMP: begin
                    if (r_depth == DW'(STACK_DEPTH)) begin
                        n_out_data.status = brse_pkg::ST_OVER;
                    end else begin
                        w_top_new   = (i_in_data.cmd == brse_pkg::CMD_PUSH_FACT) ?
                                      i_in_data.fact_flag : w_cmp;
                        w_top_mode  = brse_pkg::CELL_LOAD_ABOVE;
                        w_rest_mode = brse_pkg::CELL_LOAD_ABOVE;
                        n_depth     = r_depth + DW'(1);
                    end
                end
                brse_pkg::CMD_AND, brse_pkg::CMD_OR: begin
                    if (r_depth < DW'(2)) begin
                        n_out_data.status = brse_pkg::ST_UNDER;
                    end else begin
                        w_top_new   = (i_in_data.cmd == brse_pkg::CMD_AND) ?
                                      (w_bits[0] & w_bits[1]) : (w_bits[0] | w_bits[1]);
                        w_top_mode  = brse_pkg::CELL_LOAD_ABOVE;
                        w_rest_mode = brse_pkg::CELL_LOAD_BELOW;
                        n_depth     = r_depth - DW'(1);
                    end
                end
                brse_pkg::CMD_NOT: begin
                    if (r_depth == '0) begin
                        n_out_data.status = brse_pkg::ST_UNDER;
                    end else begin
                        w_top_new  = ~w_bits[0];
                        w_top_mode = brse_pkg::CELL_LOAD_ABOVE;
                    end
                end
                brse_pkg::CMD_HALT: begin
                    if (r_depth == '0) begin
                        n_out_data.status = brse_pkg::ST_UNDER;
                    end else begin
                        n_out_data.status  = brse_pkg::ST_HALT;
                        n_out_data.verdict = w_bits[0];
                        n_depth            = '0;
                    end
                end
                default: begin
                    n_out_data.status = brse_pkg::ST_OK;
                end
            endcase
        end
    end

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic                 w_above;
        logic                 w_below;
        brse_pkg::t_cell_mode w_mode;
        if (g == 0) begin : g_top
            assign w_above = w_top_new;
            assign w_mode  = w_top_mode;
        end else begin : g_mid
            assign w_above = w_bits[g-1];
            assign w_mode  = w_rest_mode;
        end
        if (g == STACK_DEPTH - 1) begin : g_last
            assign w_below = 1'b0;
        end else begin : g_next
            assign w_below = w_bits[g+1];
        end
        brse_cell u_cell (
            .i_clk        (i_clk),
            .i_mode       (w_mode),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_bit        (w_bits[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_depth <= n_depth;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_depth == DW'(STACK_DEPTH) &&
         (i_in_data.cmd == brse_pkg::CMD_PUSH_FACT || i_in_data.cmd == brse_pkg::CMD_PUSH_CMP))
        |=> (r_depth == DW'(STACK_DEPTH) && o_out_data.status == brse_pkg::ST_OVER))
        else $error("push on full stack changed depth or missed overflow");

    a_halt_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.cmd == brse_pkg::CMD_HALT && r_depth != '0)
        |=> (r_depth == '0 && o_out_data.status == brse_pkg::ST_HALT))
        else $error("halt did not empty the stack");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted transaction produced no result");

endmodule

FILE: hdl/brse_cell.sv
module brse_cell (
    input  logic                  i_clk,
    input  brse_pkg::t_cell_mode  i_mode,
    input  logic                  i_from_above,
    input  logic                  i_from_below,
    output logic                  o_bit
);

    logic r_bit;
    logic n_bit;

    always_comb begin
        unique case (i_mode)
            brse_pkg::CELL_LOAD_ABOVE: n_bit = i_from_above;
            brse_pkg::CELL_LOAD_BELOW: n_bit = i_from_below;
            default:                   n_bit = r_bit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
    end

    assign o_bit = r_bit;

endmodule
